>>> src/pixel_format_to_rgb565_defines.svh
// Assertion macros for the pixel format converter.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef PIXEL_FORMAT_TO_RGB565_DEFINES_SVH
`define PIXEL_FORMAT_TO_RGB565_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PF565_ASSERT(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error("pf565 assertion failed");
`define PF565_ASSERT_ALWAYS(lbl, clk_sig, prop) \
	lbl: assert property (@(posedge clk_sig) prop) \
		else $error("pf565 assertion failed");
`else
`define PF565_ASSERT(lbl, clk_sig, rst_n_sig, prop)
`define PF565_ASSERT_ALWAYS(lbl, clk_sig, prop)
`endif

`endif

>>> src/pf565_pkg.sv
// Types, constants and per-channel conversion functions for the
// pixel format converter. Depends on nothing.
package pf565_pkg;

	typedef enum logic [1:0] {
		FMT_BGR8  = 2'd0,
		FMT_BGRX8 = 2'd1,
		FMT_BGRA8 = 2'd2,
		FMT_HALF  = 2'd3
	} src_fmt_t;

	localparam logic [19:0] TONE_SCALE = 20'd585225;
	localparam logic [10:0] HALF_ONE   = 11'd1024;
	localparam logic [5:0]  MAX_WIDE   = 6'd63;
	localparam logic [5:0]  MAX_NARROW = 6'd31;
	localparam int          QW         = 12;

	typedef struct packed {
		logic [30:0] prod;
		logic [4:0]  expo;
		logic        neg;
		logic [5:0]  byte_fld;
	} chan_s2_t;

	function automatic logic [5:0] byte_field(input logic [7:0] c, input logic [7:0] a,
			input logic scaled, input logic wide);
		logic [15:0] prod;
		logic [8:0]  sc_wide;
		logic [7:0]  sc_narrow;
		logic [5:0]  res;
		prod      = 16'(c) * 16'(a);
		sc_wide   = prod[15:7];
		sc_narrow = prod[15:8];
		if (!scaled) begin
			res = wide ? c[7:2] : {1'b0, c[7:3]};
		end else if (wide) begin
			res = (sc_wide > 9'(MAX_WIDE)) ? MAX_WIDE : sc_wide[5:0];
		end else begin
			res = (sc_narrow > 8'(MAX_NARROW)) ? MAX_NARROW : sc_narrow[5:0];
		end
		return res;
	endfunction

	function automatic logic [30:0] half_prod(input logic [9:0] mant);
		return 31'(HALF_ONE + 11'(mant)) * 31'(TONE_SCALE);
	endfunction

	function automatic logic [5:0] half_field(input logic [30:0] prod, input logic [4:0] expo,
			input logic neg, input logic wide);
		logic [5:0]    sh;
		logic [30:0]   shifted;
		logic [QW-1:0] q;
		logic [5:0]    lim;
		logic [5:0]    k;
		sh      = wide ? (6'd31 - 6'(expo)) : (6'd33 - 6'(expo));
		shifted = prod >> sh;
		q       = (shifted > 31'((1 << QW) - 1)) ? {QW{1'b1}} : shifted[QW-1:0];
		lim     = wide ? MAX_WIDE : MAX_NARROW;
		k       = '0;
		for (int j = 1; j <= 63; j++) begin
			if (6'(j) <= lim && q >= QW'(j * j)) begin
				k = 6'(j);
			end
		end
		return neg ? 6'd0 : k;
	endfunction

endpackage

>>> src/pixel_format_to_rgb565.sv
// Pixel format converter: packs three source channels into one RGB565 word.
// Depends on pf565_pkg and pixel_format_to_rgb565_defines.svh.
//
// One pixel is taken every clock cycle (busy stays low) and its word appears on
// pixel_565 with done high after the three register stages below. The
// receiver cannot stall, so every done pulse must be captured when it occurs.
// The pipeline has three register stages: input capture, the product stage
// (alpha multiply or half-float tone scale), and the square-root threshold
// compare that feeds the result register. Write source_format only while no
// pixel is in flight.
`include "pixel_format_to_rgb565_defines.svh"

module pixel_format_to_rgb565 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	input  logic [15:0] chan_zero,
	input  logic [15:0] chan_one,
	input  logic [15:0] chan_two,
	input  logic [7:0]  alpha_byte,
	input  logic        end_of_image,
	output logic        done,
	output logic [15:0] pixel_565,
	output logic        end_out
);

	pf565_pkg::src_fmt_t source_format_q;

	logic                valid_s1;
	logic [15:0]         chan_s1 [3];
	logic [7:0]          alpha_s1;
	logic                end_s1;

	logic                valid_s2;
	pf565_pkg::chan_s2_t chan_s2 [3];
	logic                end_s2;

	pf565_pkg::chan_s2_t chan_nxt [3];
	logic [5:0]          fld [3];
	logic [15:0]         pixel_nxt;

	logic                done_q;
	logic [15:0]         pixel_q;
	logic                end_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= pf565_pkg::FMT_BGR8;
		end else if (cfg_wr_en) begin
			source_format_q <= pf565_pkg::src_fmt_t'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			chan_s1[0] <= chan_zero;
			chan_s1[1] <= chan_one;
			chan_s1[2] <= chan_two;
			alpha_s1   <= alpha_byte;
			end_s1     <= end_of_image;
		end
		if (valid_s1) begin
			chan_s2 <= chan_nxt;
			end_s2  <= end_s1;
		end
		if (valid_s2) begin
			pixel_q <= pixel_nxt;
			end_q   <= end_s2;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			chan_nxt[i].prod     = pf565_pkg::half_prod(chan_s1[i][9:0]);
			chan_nxt[i].expo     = chan_s1[i][14:10];
			chan_nxt[i].neg      = chan_s1[i][15];
			chan_nxt[i].byte_fld = pf565_pkg::byte_field(chan_s1[i][7:0], alpha_s1,
				source_format_q == pf565_pkg::FMT_BGRA8, i == 1);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (source_format_q == pf565_pkg::FMT_HALF) begin
				fld[i] = pf565_pkg::half_field(chan_s2[i].prod, chan_s2[i].expo,
					chan_s2[i].neg, i == 1);
			end else begin
				fld[i] = chan_s2[i].byte_fld;
			end
		end
		pixel_nxt = {fld[0][4:0], fld[1], fld[2][4:0]};
	end

	assign done      = done_q;
	assign pixel_565 = pixel_q;
	assign end_out   = end_q;

	`PF565_ASSERT(a_latency, clk, arst_n, start |-> ##3 done)
	`PF565_ASSERT(a_no_spurious, clk, arst_n, done |-> $past(start, 3))
	`PF565_ASSERT(a_half_neg_zero, clk, arst_n,
		done && $past(start && chan_zero[15] && source_format_q == pf565_pkg::FMT_HALF, 3)
		|-> pixel_565[15:11] == 5'd0)
	`PF565_ASSERT(a_bgr_truncate, clk, arst_n,
		done && $past(start && source_format_q == pf565_pkg::FMT_BGR8, 3)
		|-> pixel_565[4:0] == $past(chan_two[7:3], 3))
	`PF565_ASSERT_ALWAYS(a_never_busy, clk, !busy)

endmodule

>>> test/tb.sv
// Testbench for pixel_format_to_rgb565: drives pixels in all four source formats,
// predicts each RGB565 word and checks the words as they come out.
// Depends on pf565_pkg and the pixel_format_to_rgb565 RTL.
module tb;

	class rgb565_scoreboard;
		typedef struct packed {
			logic [15:0] word;
			logic        eoi;
		} rgb565_word_t;

		pf565_pkg::src_fmt_t fmt;
		rgb565_word_t        expected_words[$];
		int                  errors;

		function new();
			fmt = pf565_pkg::FMT_BGR8;
			errors = 0;
		endfunction

		function logic [5:0] byte_to_field(logic [15:0] chan, logic [7:0] a, bit wide);
			logic [15:0] prod;
			logic [5:0]  lim;
			lim = wide ? pf565_pkg::MAX_WIDE : pf565_pkg::MAX_NARROW;
			if (fmt != pf565_pkg::FMT_BGRA8)
				return wide ? 6'(chan[7:2]) : 6'(chan[7:3]);
			prod = 16'(chan[7:0]) * 16'(a);
			prod = wide ? (prod >> 7) : (prod >> 8);
			return (prod > 16'(lim)) ? lim : prod[5:0];
		endfunction

		function logic [5:0] half_to_field(logic [15:0] h, bit wide);
			logic [63:0] lhs;
			logic [63:0] rhs;
			logic [63:0] s;
			logic [5:0]  lim;
			lim = wide ? pf565_pkg::MAX_WIDE : pf565_pkg::MAX_NARROW;
			s = wide ? 64'd4 : 64'd8;
			if (h[15])
				return 6'd0;
			lhs = ((64'(h[9:0]) + 64'd1024) * 64'd585225) << h[14:10];
			for (int k = int'(lim); k > 0; k--) begin
				rhs = (64'(k) * 64'(k) * s * s) << 27;
				if (lhs >= rhs)
					return 6'(k);
			end
			return 6'd0;
		endfunction

		function void note_pixel(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
				logic [7:0] a, logic eoi);
			logic [5:0]   f0;
			logic [5:0]   f1;
			logic [5:0]   f2;
			rgb565_word_t w;
			if (fmt == pf565_pkg::FMT_HALF) begin
				f0 = half_to_field(c0, 1'b0);
				f1 = half_to_field(c1, 1'b1);
				f2 = half_to_field(c2, 1'b0);
			end else begin
				f0 = byte_to_field(c0, a, 1'b0);
				f1 = byte_to_field(c1, a, 1'b1);
				f2 = byte_to_field(c2, a, 1'b0);
			end
			w.word = {f0[4:0], f1[5:0], f2[4:0]};
			w.eoi = eoi;
			expected_words.push_back(w);
		endfunction

		function void check_word(logic [15:0] word, logic eoi);
			rgb565_word_t w;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word pixel_565=%h end_out=%b", $time, word, eoi);
				errors++;
				return;
			end
			w = expected_words.pop_front();
			if (word !== w.word) begin
				$display("%0t: pixel_565 expected %h actual %h", $time, w.word, word);
				errors++;
			end
			if (eoi !== w.eoi) begin
				$display("%0t: end_out expected %b actual %b", $time, w.eoi, eoi);
				errors++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cfg_wr_en;
	logic [1:0]  cfg_wr_data;
	logic [15:0] chan_zero;
	logic [15:0] chan_one;
	logic [15:0] chan_two;
	logic [7:0]  alpha_byte;
	logic        end_of_image;
	logic        done;
	logic [15:0] pixel_565;
	logic        end_out;

	rgb565_scoreboard sb = new();

	pixel_format_to_rgb565 dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.chan_zero   (chan_zero),
		.chan_one    (chan_one),
		.chan_two    (chan_two),
		.alpha_byte  (alpha_byte),
		.end_of_image(end_of_image),
		.done        (done),
		.pixel_565   (pixel_565),
		.end_out     (end_out)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_word(pixel_565, end_out);
	end

	task automatic send_pixel(input logic [15:0] c0, input logic [15:0] c1,
			input logic [15:0] c2, input logic [7:0] a, input logic eoi);
		start        <= 1'b1;
		chan_zero    <= c0;
		chan_one     <= c1;
		chan_two     <= c2;
		alpha_byte   <= a;
		end_of_image <= eoi;
		do @(posedge clk); while (busy);
		sb.note_pixel(c0, c1, c2, a, eoi);
	endtask

	task automatic idle_gap(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_for_words();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_format(input pf565_pkg::src_fmt_t f);
		wait_for_words();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= f;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.fmt = f;
	endtask

	function automatic logic [15:0] rand_chan(input pf565_pkg::src_fmt_t f);
		logic [15:0] h;
		h = 16'($urandom);
		if (f == pf565_pkg::FMT_HALF) begin
			if ($urandom_range(0, 3) != 0)
				h[15] = 1'b0;
			if ($urandom_range(0, 1) != 0)
				h[14:10] = 5'($urandom_range(0, 15));
		end
		return h;
	endfunction

	pf565_pkg::src_fmt_t fmt_order[4] = '{pf565_pkg::FMT_HALF, pf565_pkg::FMT_BGRA8,
		pf565_pkg::FMT_BGRX8, pf565_pkg::FMT_BGR8};

	initial begin
		pf565_pkg::src_fmt_t f;
		bit                  idle_on;
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = 2'd0;
		chan_zero    = 16'd0;
		chan_one     = 16'd0;
		chan_two     = 16'd0;
		alpha_byte   = 8'd0;
		end_of_image = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
		send_pixel(16'hffff, 16'hffff, 16'hffff, 8'hff, 1'b1);
		send_pixel(16'h00a5, 16'h5a3c, 16'hff81, 8'h5a, 1'b0);

		set_format(pf565_pkg::FMT_BGRX8);
		send_pixel(16'h1234, 16'hab9f, 16'h00ff, 8'h00, 1'b1);

		set_format(pf565_pkg::FMT_BGRA8);
		send_pixel(16'h00ff, 16'h00ff, 16'h00ff, 8'h00, 1'b0);
		send_pixel(16'h00ff, 16'h00ff, 16'h00ff, 8'hff, 1'b0);
		send_pixel(16'h0080, 16'h0080, 16'h0080, 8'h80, 1'b1);
		send_pixel(16'hff40, 16'h1fc0, 16'h3320, 8'hc8, 1'b0);
		send_pixel(16'h0010, 16'h0001, 16'h007f, 8'h01, 1'b1);

		set_format(pf565_pkg::FMT_HALF);
		send_pixel(16'h0000, 16'h8000, 16'h7c00, 8'hff, 1'b0);
		send_pixel(16'h7fff, 16'h3c00, 16'hffff, 8'h00, 1'b1);
		send_pixel(16'h2000, 16'h1800, 16'h2400, 8'h33, 1'b0);
		send_pixel(16'h03ff, 16'h0400, 16'h2c00, 8'hcc, 1'b0);
		send_pixel(16'h3000, 16'h2800, 16'h3400, 8'h0f, 1'b1);

		for (int phase = 0; phase < 10; phase++) begin
			f = (phase < 4) ? fmt_order[phase] :
				pf565_pkg::src_fmt_t'($urandom_range(0, 3));
			set_format(f);
			idle_on = (phase < 8) && ($urandom_range(0, 2) != 0);
			for (int i = 0; i < 40; i++) begin
				if (phase == 5 && i == 20)
					wait_for_words();
				send_pixel(rand_chan(f), rand_chan(f), rand_chan(f), 8'($urandom),
					1'($urandom_range(0, 1)));
				if (idle_on && $urandom_range(0, 3) == 0)
					idle_gap($urandom_range(1, 15));
			end
		end

		wait_for_words();
		repeat (4) @(posedge clk);
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/pf565_pkg.sv
src/pixel_format_to_rgb565.sv
test/tb.sv
